// ===== design/profile_setpoint_interpolator_assert.svh =====
// ----------------------------------------------------------------------------
// Profile setpoint interpolator assertion macros
// Macros for the concurrent checks of the interpolator controller.
// ----------------------------------------------------------------------------
`ifndef PROFILE_SETPOINT_INTERPOLATOR_ASSERT_SVH
`define PROFILE_SETPOINT_INTERPOLATOR_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define PSI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("interpolator check failed");

// The antecedent implies the consequent in the next cycle.
`define PSI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("interpolator check failed");

`endif

// ===== design/psi_pkg.sv =====
// ----------------------------------------------------------------------------
// Profile setpoint interpolator package
// Widths, reset values, field helpers and the controller interface types.
// ----------------------------------------------------------------------------
package psi_pkg;

  localparam int NumSetpoints = 6;
  localparam int IdxW         = $clog2(NumSetpoints);
  localparam int CfgIdxW      = 3;
  localparam int CfgW         = 31;
  localparam int TimeW        = 15;
  localparam int TempW        = 16;
  localparam int InW          = 16;
  localparam int OutTempW     = 10;
  localparam int StageW       = 3;
  localparam int SlopeScale   = 100;
  localparam int TempMax      = 1023;
  localparam int SlopeDivN    = TempW + 7;
  localparam int DivW         = SlopeDivN;
  localparam int CntW         = $clog2(DivW + 1);
  localparam int ScaleRemW    = 7;
  localparam int HiW          = 2 * InW;
  localparam int MagW         = HiW + 1;
  localparam int ValW         = MagW + 2;
  localparam int RecipW       = 22;
  localparam int ScaleRecipShift = 26;
  localparam int RecipProdW   = SlopeDivN - 2 + RecipW;

  localparam logic [RecipW-1:0] ScaleRecip = 22'd2684355;

  localparam logic [CfgW-1:0] SpReset [8] = '{
    31'd30, 31'd4587670, 31'd12452000, 31'd15401190,
    31'd16384230, 31'd25559070, 31'd25559070, 31'd25559070
  };

  typedef struct packed {
    logic load;
    logic scan;
    logic setup;
    logic mul;
    logic scale;
    logic reduce;
    logic finish;
  } psi_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_done;
    logic out_free;
  } psi_status_t;

  function automatic logic [TimeW-1:0] sp_time(input logic [CfgW-1:0] sp);
    return sp[TempW+TimeW-1:TempW];
  endfunction

  function automatic logic [TempW-1:0] sp_temp(input logic [CfgW-1:0] sp);
    return sp[TempW-1:0];
  endfunction

endpackage

// ===== design/psi_div.sv =====
// ----------------------------------------------------------------------------
// Profile setpoint interpolator divider
// Unsigned restoring divider, one quotient bit per cycle, variable step count.
// ----------------------------------------------------------------------------
module psi_div import psi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CntW-1:0]  count_i,
  input  logic [DivW-1:0]  dividend_i,
  input  logic [TimeW-1:0] divisor_i,
  output logic [DivW-1:0]  quotient_o,
  output logic             done_o
);

  logic             busy_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [TimeW-1:0] div_q;
  logic [TimeW-1:0] rem_q;
  logic [TimeW-1:0] rem_d;
  logic [DivW-1:0]  quo_q;
  logic [TimeW:0]   rem_shift;
  logic [TimeW:0]   rem_sub;
  logic             fits;

  always_comb begin
    rem_shift = {rem_q, quo_q[DivW-1]};
    rem_sub   = rem_shift - {1'b0, div_q};
    fits      = (rem_shift >= {1'b0, div_q});
    rem_d     = fits ? rem_sub[TimeW-1:0] : rem_shift[TimeW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= count_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DivW-2:0], fits};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ===== design/psi_dp.sv =====
// ----------------------------------------------------------------------------
// Profile setpoint interpolator datapath
// Setpoint registers, segment scan, slope and scaling arithmetic, result register.
// ----------------------------------------------------------------------------
module psi_dp import psi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic [InW-1:0]      elapsed_time_i,
  input  psi_cmd_t            cmd_i,
  output psi_status_t         status_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [OutTempW-1:0] target_temp_o,
  output logic [StageW-1:0]   stage_o,
  output logic [OutTempW-1:0] peak_temp_o,
  output logic [TimeW-1:0]    duration_o
);

  logic [CfgW-1:0]     sp_q [NumSetpoints];
  logic [InW-1:0]      t_q;
  logic [IdxW-1:0]     k_q;
  logic [IdxW-1:0]     seg_q;
  logic                seg_found_q;
  logic [IdxW-1:0]     stage_q;
  logic                stage_stop_q;
  logic [TempW-1:0]    peak_q;
  logic                neg_q;
  logic                dx_zero_q;
  logic [TempW-1:0]    y1_q;
  logic signed [InW+1:0] d_q;
  logic                neg_prod_q;
  logic [InW-1:0]      d_mag_q;
  logic [InW-1:0]      sq_q;
  logic [HiW-1:0]      hi_q;
  logic [SlopeDivN-1:0] lo_q;
  logic [MagW-1:0]     qmag_q;
  logic                out_valid_q;
  logic [OutTempW-1:0] temp_out_q;
  logic [StageW-1:0]   stage_out_q;
  logic [OutTempW-1:0] peak_out_q;
  logic [TimeW-1:0]    dur_out_q;

  logic                last_k;
  logic [IdxW-1:0]     nxt_idx;
  logic [TimeW-1:0]    tk;
  logic [TimeW-1:0]    tk_next;
  logic [TempW-1:0]    yk;
  logic                seg_last;
  logic [IdxW-1:0]     seg_hi;
  logic [TimeW-1:0]    x1;
  logic [TimeW-1:0]    x2;
  logic [TempW-1:0]    y1;
  logic [TempW-1:0]    y2;
  logic signed [TimeW:0] dx;
  logic signed [TempW:0] dy;
  logic [TimeW-1:0]    dx_mag;
  logic [TempW-1:0]    dy_mag;
  logic [SlopeDivN-1:0] dy_mag100;
  logic [SlopeDivN-1:0] slope_mag;
  logic [SlopeDivN-1:0] slope_hund;
  logic [ScaleRemW-1:0] slope_rem;
  logic [InW-1:0]      d_mag;
  logic [SlopeDivN-1:0] lo_hund;
  logic signed [ValW-1:0] value;
  logic                div_start;
  logic [CntW-1:0]     div_count;
  logic [DivW-1:0]     div_dividend;
  logic [TimeW-1:0]    div_divisor;
  logic [DivW-1:0]     quotient;
  logic                div_done;
  logic                out_free;

  // Divides by 100 as a quarter divided by 25, through a reciprocal that is
  // exact for every operand below 2^23.
  function automatic logic [SlopeDivN-1:0] div_by_scale(input logic [SlopeDivN-1:0] x);
    logic [RecipProdW-1:0] p;
    p = RecipProdW'(x[SlopeDivN-1:2]) * RecipProdW'(ScaleRecip);
    return SlopeDivN'(p >> ScaleRecipShift);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSetpoints; i++) begin
        sp_q[i] <= SpReset[i];
      end
    end else if (cfg_we_i && (int'(cfg_idx_i) < NumSetpoints)) begin
      sp_q[cfg_idx_i[IdxW-1:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    last_k   = (k_q == IdxW'(NumSetpoints - 1));
    nxt_idx  = last_k ? k_q : k_q + 1'b1;
    tk       = sp_time(sp_q[k_q]);
    tk_next  = sp_time(sp_q[nxt_idx]);
    yk       = sp_temp(sp_q[k_q]);
    seg_last = (seg_q == IdxW'(NumSetpoints - 1));
    seg_hi   = seg_last ? seg_q : seg_q + 1'b1;
    x1       = sp_time(sp_q[seg_q]);
    y1       = sp_temp(sp_q[seg_q]);
    x2       = sp_time(sp_q[seg_hi]);
    y2       = sp_temp(sp_q[seg_hi]);
    dx       = $signed({1'b0, x2}) - $signed({1'b0, x1});
    dy       = $signed({1'b0, y2}) - $signed({1'b0, y1});
    dx_mag   = dx[TimeW] ? TimeW'(-dx) : dx[TimeW-1:0];
    dy_mag   = dy[TempW] ? TempW'(-dy) : dy[TempW-1:0];
    dy_mag100 = SlopeDivN'(dy_mag) * SlopeDivN'(SlopeScale);
  end

  always_comb begin
    slope_mag  = dx_zero_q ? '0 : quotient;
    slope_hund = div_by_scale(slope_mag);
    slope_rem  = ScaleRemW'(slope_mag - SlopeDivN'(sq_q) * SlopeDivN'(SlopeScale));
    d_mag      = d_q[InW+1] ? InW'(-d_q) : InW'(d_q);
    lo_hund    = div_by_scale(lo_q);
    value      = $signed({2'b0, qmag_q});
    if (neg_prod_q) begin
      value = -value;
    end
    value = value + $signed(ValW'(y1_q));
  end

  always_comb begin
    div_start    = cmd_i.setup;
    div_count    = CntW'(SlopeDivN);
    div_dividend = dy_mag100;
    div_divisor  = dx_mag;
  end

  psi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .count_i    (div_count),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q          <= elapsed_time_i;
      k_q          <= '0;
      seg_q        <= '0;
      seg_found_q  <= 1'b0;
      stage_q      <= '0;
      stage_stop_q <= 1'b0;
      peak_q       <= '0;
    end else if (cmd_i.scan) begin
      k_q <= nxt_idx;
      if (!stage_stop_q) begin
        if (t_q < InW'(tk)) begin
          stage_stop_q <= 1'b1;
        end else begin
          stage_q <= k_q;
        end
      end
      if (yk > peak_q) begin
        peak_q <= yk;
      end
      if (!seg_found_q && (last_k || (t_q < InW'(tk_next)))) begin
        seg_q       <= k_q;
        seg_found_q <= 1'b1;
      end
    end
    if (cmd_i.setup) begin
      neg_q     <= dx[TimeW] ^ dy[TempW];
      dx_zero_q <= (dx == '0);
      y1_q      <= y1;
      d_q       <= $signed({2'b0, t_q}) - $signed({3'b0, x1});
    end
    if (cmd_i.mul) begin
      sq_q       <= InW'(slope_hund);
      d_mag_q    <= d_mag;
      neg_prod_q <= neg_q ^ d_q[InW+1];
    end
    if (cmd_i.scale) begin
      hi_q <= HiW'(sq_q) * HiW'(d_mag_q);
      lo_q <= SlopeDivN'(slope_rem) * SlopeDivN'(d_mag_q);
    end
    if (cmd_i.reduce) begin
      qmag_q <= MagW'(hi_q) + MagW'(lo_hund);
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (value < 0) begin
        temp_out_q <= '0;
      end else if (value > $signed(ValW'(TempMax))) begin
        temp_out_q <= OutTempW'(TempMax);
      end else begin
        temp_out_q <= value[OutTempW-1:0];
      end
      stage_out_q <= StageW'(stage_q);
      peak_out_q  <= (peak_q > TempW'(TempMax)) ? OutTempW'(TempMax)
                                                : peak_q[OutTempW-1:0];
      dur_out_q   <= sp_time(sp_q[NumSetpoints-1]);
    end
  end

  assign status_o.scan_last = last_k;
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = out_free;
  assign out_valid_o        = out_valid_q;
  assign target_temp_o      = temp_out_q;
  assign stage_o            = stage_out_q;
  assign peak_temp_o        = peak_out_q;
  assign duration_o         = dur_out_q;

endmodule

// ===== design/psi_ctrl.sv =====
// ----------------------------------------------------------------------------
// Profile setpoint interpolator controller
// Sequences the scan, the slope division, the product and the scaling division.
// ----------------------------------------------------------------------------
`include "profile_setpoint_interpolator_assert.svh"

module psi_ctrl import psi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  psi_status_t status_i,
  output psi_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETUP,
    ST_DIV_SLOPE,
    ST_MUL,
    ST_SCALE,
    ST_DIV_SCALE,
    ST_FINISH
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status_i.scan_last) begin
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          state_q <= ST_DIV_SLOPE;
        end
        ST_DIV_SLOPE: begin
          if (status_i.div_done) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          state_q <= ST_DIV_SCALE;
        end
        ST_DIV_SCALE: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.scan   = (state_q == ST_SCAN);
    cmd_o.setup  = (state_q == ST_SETUP);
    cmd_o.mul    = (state_q == ST_MUL);
    cmd_o.scale  = (state_q == ST_SCALE);
    cmd_o.reduce = (state_q == ST_DIV_SCALE);
    cmd_o.finish = (state_q == ST_FINISH) && status_i.out_free;
  end

  assign in_stall_o = (state_q != ST_IDLE);

  `PSI_ASSERT_NXT(a_slope_to_mul, state_q == ST_DIV_SLOPE && status_i.div_done, state_q == ST_MUL)
  `PSI_ASSERT_IMP(a_finish_free, cmd_o.finish, status_i.out_free)
  `PSI_ASSERT_NXT(a_finish_idle, cmd_o.finish, state_q == ST_IDLE && !in_stall_o)

endmodule

// ===== design/profile_setpoint_interpolator.sv =====
// ----------------------------------------------------------------------------
// Profile setpoint interpolator
// Target temperature of a setpoint profile at a given elapsed time.
// ----------------------------------------------------------------------------
// The input channel takes an elapsed time in seconds (valid and stall); the
// output channel gives the interpolated target temperature, the stage index,
// the peak setpoint temperature and the profile duration for each item.
// Setpoints are to be written through the configuration port only while the
// block idles; the block itself does not enforce this. One item is worked on
// at a time. An item scans the setpoints one per cycle, runs the slope
// division on a one-bit-per-cycle divider (23 steps), and then scales the
// product by 100 with a reciprocal multiplication in the multiply, scale and
// reduce states. The result is registered in the finish state, and the next
// item can be taken in the cycle after, when the block is back in idle.
// The result register lets the next item be accepted while a result waits.
// If the receiver stalls, a finished item waits until the result register is
// free, and input stall stays high meanwhile. Reset loads the default profile
// and leaves both channels empty.
// ----------------------------------------------------------------------------
module profile_setpoint_interpolator import psi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [InW-1:0]      elapsed_time_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OutTempW-1:0] target_temp_o,
  output logic [StageW-1:0]   stage_o,
  output logic [OutTempW-1:0] peak_temp_o,
  output logic [TimeW-1:0]    duration_o
);

  psi_cmd_t    cmd;
  psi_status_t status;

  psi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  psi_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .elapsed_time_i (elapsed_time_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .target_temp_o  (target_temp_o),
    .stage_o        (stage_o),
    .peak_temp_o    (peak_temp_o),
    .duration_o     (duration_o)
  );

endmodule
